// ----- design/sha224_pkg.sv -----
// sha224 package: shared types, initial hash values and round constants
// no dependencies

package sha224_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } item_type;

   localparam int QueueDepth = 4;

   localparam logic [31:0] InitH [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ----- design/sha224_queue.sv -----
// sha224 item queue between front and back
// depends on sha224_pkg

module sha224_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_has_byte,
   input  logic                req_last,
   output logic                q_valid,
   input  logic                q_ready,
   output sha224_pkg::item_type q_item
);
   import sha224_pkg::*;

   localparam int AW = $clog2(QueueDepth);

   item_type          mem_ff [QueueDepth];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign req_ready = (cnt_ff != (AW+1)'(QueueDepth));
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = mem_ff[rd_ff];
   assign push = req_valid && req_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{data_byte: req_data_byte, has_byte: req_has_byte, last: req_last};
      end
   end

endmodule

// ----- design/sha224_core.sv -----
// sha224 back end: block buffer, padding, one round per cycle, digest output
// depends on sha224_pkg

module sha224_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  sha224_pkg::item_type q_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_digest_word,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word
);
   import sha224_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LOAD  = 6'b000010,
      S_ROUND = 6'b000100,
      S_FOLD  = 6'b001000,
      S_PAD   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   logic [31:0]  blk_ff [16];
   logic [5:0]   fill_ff;
   logic [63:0]  bits_ff;
   logic [31:0]  h_ff [8];
   logic [31:0]  v_ff [8];
   logic [31:0]  w_ff [16];
   logic [6:0]   rnd_ff;
   logic [5:0]   pad_ff;
   logic         final_ff;
   logic         second_ff;
   logic         len_done_ff;
   logic [2:0]   oidx_ff;

   logic [5:0]  r;
   logic [31:0] wv, w15, w2, s0, s1, t1, t2;
   logic [31:0] a, b, c, d, e, f, g, h;

   assign r = rnd_ff[5:0];
   assign {a, b, c, d} = {v_ff[0], v_ff[1], v_ff[2], v_ff[3]};
   assign {e, f, g, h} = {v_ff[4], v_ff[5], v_ff[6], v_ff[7]};

   always_comb begin
      w15 = w_ff[4'(r - 6'd15)];
      w2  = w_ff[4'(r - 6'd2)];
      s0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
      s1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
      if (rnd_ff < 7'd16) begin
         wv = blk_ff[r[3:0]];
      end else begin
         wv = w_ff[4'(r - 6'd16)] + s0 + w_ff[4'(r - 6'd7)] + s1;
      end
      t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & f) ^ (~e & g)) + round_k(r) + wv;
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & b) ^ (a & c) ^ (b & c));
   end

   assign q_ready         = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = h_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd6);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_item.has_byte && fill_ff == 6'd63) state_in = S_LOAD;
               else if (q_item.last) state_in = S_PAD;
            end
         end
         S_LOAD:  state_in = S_ROUND;
         S_ROUND: if (rnd_ff == 7'd63) state_in = S_FOLD;
         S_FOLD: begin
            if (!final_ff) state_in = S_IDLE;
            else if (len_done_ff) state_in = S_OUT;
            else state_in = S_PAD;
         end
         S_PAD:   if (pad_ff == 6'd63) state_in = S_LOAD;
         S_OUT:   if (rsp_ready && oidx_ff == 3'd6) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         bits_ff     <= '0;
         rnd_ff      <= '0;
         pad_ff      <= '0;
         final_ff    <= 1'b0;
         second_ff   <= 1'b0;
         len_done_ff <= 1'b0;
         oidx_ff     <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
         for (int i = 0; i < 8; i++) v_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  final_ff    <= q_item.last;
                  second_ff   <= 1'b0;
                  len_done_ff <= 1'b0;
                  if (q_item.has_byte) begin
                     fill_ff <= fill_ff + 1'b1;
                     bits_ff <= bits_ff + 64'd8;
                  end
                  pad_ff <= q_item.has_byte ? fill_ff + 1'b1 : fill_ff;
               end
            end
            S_LOAD: begin
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               rnd_ff <= '0;
            end
            S_ROUND: begin
               v_ff[7] <= g; v_ff[6] <= f; v_ff[5] <= e; v_ff[4] <= d + t1;
               v_ff[3] <= c; v_ff[2] <= b; v_ff[1] <= a; v_ff[0] <= t1 + t2;
               rnd_ff  <= (rnd_ff == 7'd63) ? '0 : rnd_ff + 1'b1;
            end
            S_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               oidx_ff <= '0;
            end
            S_PAD: begin
               pad_ff <= pad_ff + 1'b1;
               if (pad_ff == 6'd63) begin
                  // a marker past byte 55 leaves no room for the length: pad again from 0
                  if (fill_ff < 6'd56 || second_ff) len_done_ff <= 1'b1;
                  else second_ff <= 1'b1;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  oidx_ff <= (oidx_ff == 3'd6) ? '0 : oidx_ff + 1'b1;
                  if (oidx_ff == 3'd6) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= InitH[i];
                     fill_ff  <= '0;
                     bits_ff  <= '0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // padding: marker written at fill position, later bytes zero or length
   logic        pad_mark;
   logic        marked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         marked_ff <= 1'b0;
      end else if (state_ff == S_IDLE && q_valid) begin
         marked_ff <= 1'b0;
      end else if (state_ff == S_PAD) begin
         marked_ff <= 1'b1;
      end
   end
   assign pad_mark = !marked_ff;

   // block buffer as big-endian words and schedule window
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid && q_item.has_byte) begin
         blk_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'd0} +: 8] <= q_item.data_byte;
      end else if (state_ff == S_PAD) begin
         if (pad_mark) begin
            blk_ff[pad_ff[5:2]][{~pad_ff[1:0], 3'd0} +: 8] <= 8'h80;
         end else if (pad_ff >= 6'd56 && fill_ff < 6'd56 || pad_ff >= 6'd56 && second_ff) begin
            blk_ff[pad_ff[5:2]][{~pad_ff[1:0], 3'd0} +: 8] <=
               bits_ff[6'd63 - {pad_ff[2:0], 3'd0} -: 8];
         end else begin
            blk_ff[pad_ff[5:2]][{~pad_ff[1:0], 3'd0} +: 8] <= 8'h00;
         end
      end
      if (state_ff == S_ROUND) begin
         w_ff[r[3:0]] <= wv;
      end
   end

endmodule

// ----- design/sha224_stream_hasher_top.sv -----
// sha224 stream hasher: one byte per item in, seven digest words out
// items go via the queue into the block buffer; a full block runs load, round and fold
// throughput: one byte item per cycle while core is not hashing, padding or sending
// last item: pad and hash, then one digest word per cycle while rsp_ready is high
// reset clears control state and loads the initial hash values
// depends on sha224_pkg, sha224_queue, sha224_core

module sha224_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha224_pkg::*;

   logic     q_valid, q_ready;
   item_type q_item;

   sha224_queue u_queue (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_has_byte,
      .req_last, .q_valid, .q_ready, .q_item
   );

   sha224_core u_core (
      .clock, .reset, .q_valid, .q_ready, .q_item, .rsp_valid, .rsp_ready,
      .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd6)))
      else $error("last_word mismatch");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index))
      else $error("result dropped");

endmodule

// ----- sim/sha224_stream_hasher_top_tb.sv -----
// testbench for sha224_stream_hasher_top: random byte streams with idling on both sides
// digests predicted by an in-bench sha-224 model and checked word by word
// depends on sha224_pkg and the hasher rtl

module sha224_stream_hasher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sha224_pkg::*;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_word;
   } digest_rec_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 0;
   logic        req_has_byte = 0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha224_stream_hasher_top i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   item_type       pending_items[$];
   digest_rec_type expected_words[$];
   int             failures = 0;
   bit             drain_hold = 0;

   // hash model state
   logic [7:0]  blk_bytes[64];
   int          blk_fill;
   logic [31:0] chain_h[8];
   logic [63:0] msg_bits;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_compress();
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int r = 0; r < 16; r++)
         w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
      for (int r = 16; r < 64; r++) begin
         s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                  chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
      for (int r = 0; r < 64; r++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + round_k(r[5:0]) + w[r];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   function automatic void start_msg();
      for (int i = 0; i < 8; i++) chain_h[i] = InitH[i];
      blk_fill = 0;
      msg_bits = 0;
   endfunction

   function automatic void predict_digest(item_type it);
      int i;
      digest_rec_type rec;
      if (it.has_byte) begin
         blk_bytes[blk_fill] = it.data_byte;
         blk_fill++;
         msg_bits += 8;
         if (blk_fill == 64) begin
            sha_compress();
            blk_fill = 0;
         end
      end
      if (!it.last) return;
      i = blk_fill;
      blk_bytes[i++] = 8'h80;
      if (i > 56) begin
         while (i < 64) blk_bytes[i++] = 0;
         sha_compress();
         i = 0;
      end
      while (i < 56) blk_bytes[i++] = 0;
      for (int k = 0; k < 8; k++) blk_bytes[56+k] = msg_bits[63-8*k -: 8];
      sha_compress();
      for (int k = 0; k < 7; k++) begin
         rec.word = chain_h[k];
         rec.index = k[2:0];
         rec.last_word = (k == 6);
         expected_words.push_back(rec);
      end
      start_msg();
   endfunction

   function automatic int gap_len();
      int p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic item_type mk_item(logic [7:0] d, logic hb, logic lst);
      item_type it;
      it.data_byte = d;
      it.has_byte = hb;
      it.last = lst;
      return it;
   endfunction

   function automatic void queue_message(int len, bit noise);
      for (int k = 0; k < len; k++) begin
         if (noise && $urandom_range(0, 9) == 0)
            pending_items.push_back(mk_item(8'($urandom), 0, 0));
         pending_items.push_back(mk_item(8'($urandom), 1,
                                         (k == len - 1) && $urandom_range(0, 1)));
         if (pending_items[$].last) return;
      end
      pending_items.push_back(mk_item(8'($urandom), 0, 1));
   endfunction

   // driver
   int  send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_digest({req_data_byte, req_has_byte, req_last});
            send_gap = gap_len();
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0 || pending_items.size() == 0
                || (drain_hold && expected_words.size() != 0)) begin
               if (send_gap > 0) send_gap--;
               req_valid <= 0;
            end else begin
               {req_data_byte, req_has_byte, req_last} <= pending_items.pop_front();
               req_valid <= 1;
            end
         end
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      digest_rec_type exp_rec;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("digest word with no expectation: %h", rsp_digest_word);
               failures++;
            end else begin
               exp_rec = expected_words.pop_front();
               if (rsp_digest_word !== exp_rec.word) begin
                  $error("digest_word exp %h got %h", exp_rec.word, rsp_digest_word);
                  failures++;
               end
               if (rsp_word_index !== exp_rec.index) begin
                  $error("word_index exp %0d got %0d", exp_rec.index, rsp_word_index);
                  failures++;
               end
               if (rsp_last_word !== exp_rec.last_word) begin
                  $error("last_word exp %0d got %0d", exp_rec.last_word, rsp_last_word);
                  failures++;
               end
            end
            recv_gap = gap_len();
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 0;
         end else
            rsp_ready <= 1;
      end
   end

   initial begin
      start_msg();
      for (int i = 0; i < 64; i++) blk_bytes[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed: empty message, ignored idle items, edge byte values, two-block padding
      pending_items.push_back(mk_item(8'hff, 0, 0));
      pending_items.push_back(mk_item(8'hff, 0, 1));
      pending_items.push_back(mk_item(8'h00, 1, 0));
      pending_items.push_back(mk_item(8'hff, 1, 1));
      pending_items.push_back(mk_item(8'h61, 1, 0));
      pending_items.push_back(mk_item(8'h62, 1, 0));
      pending_items.push_back(mk_item(8'h63, 1, 1));
      for (int k = 0; k < 60; k++)
         pending_items.push_back(mk_item(k[7:0], 1, k == 59));
      wait (pending_items.size() == 0);
      drain_hold = 1;
      wait (expected_words.size() == 0 && !req_valid);
      drain_hold = 0;
      // random: short messages
      for (int m = 0; m < 5; m++) begin
         queue_message($urandom_range(0, 8), 1);
         wait (pending_items.size() == 0);
      end
      wait (!req_valid);
      wait (expected_words.size() == 0);
      repeat (300) @(posedge clock);
      if (failures == 0 && expected_words.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/sha224_pkg.sv
design/sha224_queue.sv
design/sha224_core.sv
design/sha224_stream_hasher_top.sv
sim/sha224_stream_hasher_top_tb.sv
